### src/spq_pkg.sv
`timescale 1ns / 1ps
// Shared operation codes, status codes and controller command type for the priority queue.
package spq_pkg;

   localparam int StatusWidth = 2;

   typedef logic [StatusWidth-1:0] status_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   localparam status_type STATUS_INSERTED = 2'd0;
   localparam status_type STATUS_POPPED   = 2'd1;
   localparam status_type STATUS_EMPTY    = 2'd2;
   localparam status_type STATUS_FULL     = 2'd3;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

### src/spq_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the priority queue.
interface spq_req_if #(
   parameter int PRIO_WIDTH = 16,
   parameter int TAG_WIDTH  = 32
);
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic signed [PRIO_WIDTH-1:0] entry_priority_in;
   logic        [TAG_WIDTH-1:0]  entry_tag_in;

   modport source (output valid, output req_type, output entry_priority_in,
                   output entry_tag_in, input ready);
   modport sink   (input valid, input req_type, input entry_priority_in,
                   input entry_tag_in, output ready);
endinterface

interface spq_rsp_if #(
   parameter int PRIO_WIDTH = 16,
   parameter int TAG_WIDTH  = 32,
   parameter int CNT_WIDTH  = 5
);
   logic                         valid;
   logic                         ready;
   logic signed [PRIO_WIDTH-1:0] popped_priority;
   logic        [TAG_WIDTH-1:0]  popped_tag;
   spq_pkg::status_type          status;
   logic        [CNT_WIDTH-1:0]  occupancy;

   modport source (output valid, output popped_priority, output popped_tag,
                   output status, output occupancy, input ready);
   modport sink   (input valid, input popped_priority, input popped_tag,
                   input status, input occupancy, output ready);
endinterface

### src/spq_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences capture and commit of each request.
module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::cmd_type cmd
);
   import spq_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.commit  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd.commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A commit always presents a response in the following cycle.
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit did not raise response valid");

   // A captured request is never accepted alongside another one.
   a_capture_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_ready && !cmd.capture)
      else $error("request accepted while one is in progress");

endmodule

### src/spq_datapath.sv
`timescale 1ns / 1ps
// Sorted slot chain, fill count and response registers of the priority queue.
module spq_datapath #(
   parameter int DEPTH      = 16,
   parameter int PRIO_WIDTH = 16,
   parameter int TAG_WIDTH  = 32,
   parameter int CNT_WIDTH  = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  spq_pkg::cmd_type             cmd,
   input  logic                         req_type,
   input  logic signed [PRIO_WIDTH-1:0] entry_priority_in,
   input  logic        [TAG_WIDTH-1:0]  entry_tag_in,
   output logic signed [PRIO_WIDTH-1:0] popped_priority,
   output logic        [TAG_WIDTH-1:0]  popped_tag,
   output spq_pkg::status_type          status,
   output logic        [CNT_WIDTH-1:0]  occupancy
);
   import spq_pkg::*;

   logic                         op_ff;
   logic signed [PRIO_WIDTH-1:0] prio_ff;
   logic        [TAG_WIDTH-1:0]  tag_ff;
   logic        [CNT_WIDTH-1:0]  count_ff, count_in;

   logic signed [PRIO_WIDTH-1:0] slot_prio_ff [DEPTH];
   logic        [TAG_WIDTH-1:0]  slot_tag_ff  [DEPTH];

   logic signed [PRIO_WIDTH-1:0] up_prio   [DEPTH];
   logic        [TAG_WIDTH-1:0]  up_tag    [DEPTH];
   logic signed [PRIO_WIDTH-1:0] down_prio [DEPTH];
   logic        [TAG_WIDTH-1:0]  down_tag  [DEPTH];

   logic [DEPTH-1:0] keep;
   logic [DEPTH-1:0] keep_prev;
   logic             full, empty, insert_go, pop_go;
   status_type       status_in;

   logic signed [PRIO_WIDTH-1:0] popped_priority_ff;
   logic        [TAG_WIDTH-1:0]  popped_tag_ff;
   status_type                   status_ff;
   logic        [CNT_WIDTH-1:0]  occupancy_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_type;
         prio_ff <= entry_priority_in;
         tag_ff  <= entry_tag_in;
      end
   end

   assign full      = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty     = (count_ff == '0);
   assign insert_go = cmd.commit && (op_ff == OP_INSERT) && !full;
   assign pop_go    = cmd.commit && (op_ff == OP_POP) && !empty;

   // Each occupied slot whose priority is at least the new one stays in place.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         keep[i] = (CNT_WIDTH'(i) < count_ff) && (slot_prio_ff[i] >= prio_ff);
      end
   end

   assign keep_prev = {keep[DEPTH-2:0], 1'b1};

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_slot
      if (gi == 0) begin : g_head
         assign up_prio[gi] = prio_ff;
         assign up_tag[gi]  = tag_ff;
      end else begin : g_body
         assign up_prio[gi] = slot_prio_ff[gi-1];
         assign up_tag[gi]  = slot_tag_ff[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
         assign down_prio[gi] = slot_prio_ff[gi];
         assign down_tag[gi]  = slot_tag_ff[gi];
      end else begin : g_mid
         assign down_prio[gi] = slot_prio_ff[gi+1];
         assign down_tag[gi]  = slot_tag_ff[gi+1];
      end

      always_ff @(posedge clock) begin
         if (insert_go && !keep[gi]) begin
            slot_prio_ff[gi] <= keep_prev[gi] ? prio_ff : up_prio[gi];
            slot_tag_ff[gi]  <= keep_prev[gi] ? tag_ff : up_tag[gi];
         end else if (pop_go) begin
            slot_prio_ff[gi] <= down_prio[gi];
            slot_tag_ff[gi]  <= down_tag[gi];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (insert_go) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (pop_go) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_comb begin
      case ({op_ff, (op_ff == OP_INSERT) ? full : empty})
         {OP_INSERT, 1'b0}: status_in = STATUS_INSERTED;
         {OP_INSERT, 1'b1}: status_in = STATUS_FULL;
         {OP_POP, 1'b0}:    status_in = STATUS_POPPED;
         {OP_POP, 1'b1}:    status_in = STATUS_EMPTY;
         default:           status_in = STATUS_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         popped_priority_ff <= pop_go ? slot_prio_ff[0] : '0;
         popped_tag_ff      <= pop_go ? slot_tag_ff[0] : '0;
         status_ff          <= status_in;
         occupancy_ff       <= count_in;
      end
   end

   assign popped_priority = popped_priority_ff;
   assign popped_tag      = popped_tag_ff;
   assign status          = status_ff;
   assign occupancy       = occupancy_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(DEPTH))
      else $error("fill count exceeds depth");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      insert_go |=> count_ff == $past(count_ff) + CNT_WIDTH'(1))
      else $error("insert did not advance fill count");

   // The two front entries stay in priority order.
   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_WIDTH'(2) |-> slot_prio_ff[0] >= slot_prio_ff[1])
      else $error("front slots out of priority order");

endmodule

### src/stable_priority_queue.sv
`timescale 1ns / 1ps
// Top level of the stable priority queue: controller, slot datapath and channel wiring.
//
//   Channel   Direction  Payload
//   req_bus   in         req_type, entry_priority_in, entry_tag_in
//   rsp_bus   out        popped_priority, popped_tag, status, occupancy
//
// Each transaction first captures the request, then commits it in the execute state,
// in which every slot compares against the new priority and shifts in parallel.
// A new request is taken while the previous response still waits in its register.
// A stalled response holds the commit of the following request until it is taken.
// Synchronous reset empties the queue; slot contents are not cleared.
module stable_priority_queue #(
   parameter int DEPTH      = 16,
   parameter int PRIO_WIDTH = 16,
   parameter int TAG_WIDTH  = 32
) (
   input logic clock,
   input logic reset,
   spq_req_if.sink   req_bus,
   spq_rsp_if.source rsp_bus
);
   import spq_pkg::*;

   localparam int CntWidth = $clog2(DEPTH + 1);

   cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   spq_datapath #(
      .DEPTH      (DEPTH),
      .PRIO_WIDTH (PRIO_WIDTH),
      .TAG_WIDTH  (TAG_WIDTH),
      .CNT_WIDTH  (CntWidth)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_type          (req_bus.req_type),
      .entry_priority_in (req_bus.entry_priority_in),
      .entry_tag_in      (req_bus.entry_tag_in),
      .popped_priority   (rsp_bus.popped_priority),
      .popped_tag        (rsp_bus.popped_tag),
      .status            (rsp_bus.status),
      .occupancy         (rsp_bus.occupancy)
   );

endmodule
